### rtl/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg
// Shared types and constants for the hue/saturation to RGB converter.
// ----------------------------------------------------------------------------
package hsr_pkg;

  // Input item: hue in degrees, saturation in percent
  typedef struct packed {
    logic [8:0] hue_degrees;
    logic [6:0] saturation_percent;
  } hsr_in_t;

  // Result item: 8-bit color channels
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsr_out_t;

  localparam int unsigned NumChan = 3;

  typedef logic [5:0]  hsr_frac_t;   // F in 0..60
  typedef logic [12:0] hsr_diff_t;   // 6000 - sat*F
  typedef logic [12:0] hsr_quot_t;   // (17*D) >> 4

  // Channel order: red, green, blue. Offset is 60*n for n = 5, 3, 1.
  localparam logic [NumChan-1:0][9:0] ChanOffset = {10'd60, 10'd180, 10'd300};

  localparam logic [9:0]  CircleDeg  = 10'd360;
  localparam logic [9:0]  TwoCircle  = 10'd720;
  localparam logic [8:0]  PeakDeg    = 9'd240;
  localparam logic [8:0]  SectorDeg  = 9'd60;
  localparam logic [6:0]  SatMax     = 7'd100;
  localparam logic [12:0] Denom      = 13'd6000;
  // 255/6000 = 17/400 = (17/16)/25; /25 as *5243 >> 17, exact for y < 8192
  localparam logic [4:0]  ScaleNum   = 5'd17;
  localparam logic [12:0] RecipMul   = 13'd5243;
  localparam int unsigned RecipShift = 17;

endpackage

### rtl/hsr_sector.sv
// ----------------------------------------------------------------------------
// hsr_sector
// Stage 1: wraps hue per channel, forms the clamped ramp F, clamps saturation.
// ----------------------------------------------------------------------------
module hsr_sector import hsr_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  hsr_in_t                        item_i,
  output logic                           valid_o,
  output logic [6:0]                     sat_o,
  output logic [NumChan-1:0][5:0]        frac_o
);

  logic                    valid_q;
  logic [6:0]              sat_d, sat_q;
  logic [NumChan-1:0][5:0] frac_d, frac_q;

  always_comb begin
    logic [9:0] sum;
    logic [8:0] k;
    logic [8:0] other;
    logic [8:0] m;
    sat_d = (item_i.saturation_percent > SatMax) ? SatMax : item_i.saturation_percent;
    for (int c = 0; c < NumChan; c++) begin
      sum = {1'b0, item_i.hue_degrees} + ChanOffset[c];
      if (sum >= TwoCircle) begin
        sum = sum - TwoCircle;
      end else if (sum >= CircleDeg) begin
        sum = sum - CircleDeg;
      end
      k     = sum[8:0];
      other = PeakDeg - k;
      m     = (k < other) ? k : other;
      if (k >= PeakDeg) begin
        frac_d[c] = '0;
      end else if (m > SectorDeg) begin
        frac_d[c] = SectorDeg[5:0];
      end else begin
        frac_d[c] = m[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q  <= sat_d;
    frac_q <= frac_d;
  end

  assign valid_o = valid_q;
  assign sat_o   = sat_q;
  assign frac_o  = frac_q;

endmodule

### rtl/hsr_scale.sv
// ----------------------------------------------------------------------------
// hsr_scale
// Stages 2-4: sat*F, scale by 17/16, divide by 25 via reciprocal multiply.
// ----------------------------------------------------------------------------
module hsr_scale import hsr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [6:0]              sat_i,
  input  logic [NumChan-1:0][5:0] frac_i,
  output logic                    valid_o,
  output hsr_out_t                result_o
);

  logic [2:0]                 valid_q;
  hsr_diff_t [NumChan-1:0]    diff_d, diff_q;
  hsr_quot_t [NumChan-1:0]    quot_d, quot_q;
  logic [NumChan-1:0][7:0]    chan_d, chan_q;

  // stage 2: D = 6000 - sat*F  (sat*F <= 6000)
  always_comb begin
    logic [12:0] prod;
    for (int c = 0; c < NumChan; c++) begin
      prod      = 13'(sat_i * frac_i[c]);
      diff_d[c] = Denom - prod;
    end
  end

  // stage 3: y = (17*D) >> 4
  always_comb begin
    logic [16:0] x;
    for (int c = 0; c < NumChan; c++) begin
      x         = 17'(diff_q[c] * ScaleNum);
      quot_d[c] = x[16:4];
    end
  end

  // stage 4: y / 25
  always_comb begin
    logic [25:0] r;
    for (int c = 0; c < NumChan; c++) begin
      r         = 26'(quot_q[c] * RecipMul);
      chan_d[c] = r[RecipShift +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    quot_q <= quot_d;
    chan_q <= chan_d;
  end

  assign valid_o        = valid_q[2];
  assign result_o.red   = chan_q[0];
  assign result_o.green = chan_q[1];
  assign result_o.blue  = chan_q[2];

endmodule

### rtl/hue_saturation_to_rgb.sv
// ----------------------------------------------------------------------------
// hue_saturation_to_rgb
// HSV to RGB at full value: hue in degrees, saturation in percent, 8-bit RGB.
// ----------------------------------------------------------------------------
// Each accepted item passes the stage 1 register, then the stage 2-4 registers.
// Throughput: one item per cycle; busy is never raised, so start may stay high.
// Each result is shown for one cycle with valid_o; the receiver cannot stall.
// Reset (rst_ni, async, active low) clears the valid pipeline only; no
// items are in flight afterwards and the data path needs no init.
module hue_saturation_to_rgb import hsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  hsr_in_t  item_i,
  output logic     valid_o,
  output hsr_out_t result_o
);

  logic                    s1_valid;
  logic [6:0]              s1_sat;
  logic [NumChan-1:0][5:0] s1_frac;

  // Every stage advances each cycle and the output cannot be held off,
  // so there is never a reason to refuse an item.
  assign busy = 1'b0;

  // Stage 1: hue wrap per channel (two compare/subtract steps), ramp F
  // with its clamp, and saturation clamp to 100 %.
  hsr_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .item_i  (item_i),
    .valid_o (s1_valid),
    .sat_o   (s1_sat),
    .frac_o  (s1_frac)
  );

  // Stages 2-4: 255*(6000 - s*F)/6000 rewritten as ((17*D) >> 4) / 25,
  // one narrow multiply per stage, the last stage's register is the output.
  hsr_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .sat_i    (s1_sat),
    .frac_i   (s1_frac),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

endmodule

### rtl/hsr_checker.sv
// ----------------------------------------------------------------------------
// hsr_checker
// Port-level assertions for hue_saturation_to_rgb, bound to the top level.
// ----------------------------------------------------------------------------
module hsr_checker import hsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  hsr_in_t  item_i,
  input  logic     valid_o,
  input  hsr_out_t result_o
);

  logic acc;
  assign acc = start & ~busy;

  // every accepted item produces a result on valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##4 valid_o)
    else $error("accepted item did not produce a result");

  // no result without an earlier accepted item
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(acc, 4))
    else $error("result without accepted item");

  // zero saturation gives white
  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(item_i.saturation_percent, 4) == 7'd0)
      |-> (result_o.red == 8'd255 && result_o.green == 8'd255 &&
           result_o.blue == 8'd255))
    else $error("zero saturation not white");

  // full saturation at hue zero gives pure red
  a_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(item_i.saturation_percent, 4) >= 7'd100 &&
     $past(item_i.hue_degrees, 4) == 9'd0)
      |-> (result_o.red == 8'd255 && result_o.green == 8'd0 &&
           result_o.blue == 8'd0))
    else $error("full saturation at hue zero not pure red");

endmodule

bind hue_saturation_to_rgb hsr_checker u_hsr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .valid_o  (valid_o),
  .result_o (result_o)
);

### test/hue_saturation_to_rgb_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hue_saturation_to_rgb_tb
// Self-checking bench for the full-value HSV to RGB converter. Items carry a
// hue and a saturation. Every accepted item gets an RGB prediction that is
// computed here in exact integer arithmetic. Each strobed result is checked
// per channel against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hue_saturation_to_rgb_tb;
  import hsr_pkg::*;

  // Pipeline depth of the converter, plus some slack for the drain
  localparam int unsigned PipeDepth   = 4;
  localparam int unsigned DrainGuard  = 200;
  localparam int unsigned RandomItems = 1230;

  // Channel sector offsets in degrees (60*n for n = 5, 3, 1)
  localparam int unsigned RedOffset   = 300;
  localparam int unsigned GreenOffset = 180;
  localparam int unsigned BlueOffset  = 60;

  // Tracks predicted colors and compares them with what comes out
  class rgb_scoreboard;
    hsr_out_t    expected_rgb[$];
    int unsigned mismatches;
    int unsigned items_seen;
    int unsigned colors_checked;
    int unsigned hue_wraps;
    int unsigned sat_clamps;
    int unsigned whites;

    function new();
      mismatches     = 0;
      items_seen     = 0;
      colors_checked = 0;
      hue_wraps      = 0;
      sat_clamps     = 0;
      whites         = 0;
    endfunction

    // One channel: K = (offset + hue) mod 360, F = clamp(min(K, 240 - K), 0, 60)
    static function logic [7:0] channel_level(int unsigned offset_deg,
                                              int unsigned hue,
                                              int unsigned sat);
      int unsigned k;
      int unsigned f;
      k = (offset_deg + hue) % 360;
      if (k >= 240) begin
        f = 0;
      end else begin
        f = (k < 240 - k) ? k : 240 - k;
        if (f > 60) f = 60;
      end
      return 8'((255 * (6000 - sat * f)) / 6000);
    endfunction

    function void note_item(hsr_in_t req);
      int unsigned hue;
      int unsigned sat;
      hsr_out_t    rgb;
      hue = req.hue_degrees;
      sat = req.saturation_percent;
      if (hue > 360) hue_wraps++;
      if (sat > 100) begin
        sat = 100;
        sat_clamps++;
      end
      if (sat == 0) whites++;
      rgb.red   = channel_level(RedOffset, hue, sat);
      rgb.green = channel_level(GreenOffset, hue, sat);
      rgb.blue  = channel_level(BlueOffset, hue, sat);
      expected_rgb.push_back(rgb);
      items_seen++;
    endfunction

    function void check_color(hsr_out_t got);
      hsr_out_t want;
      if (expected_rgb.size() == 0) begin
        $error("color result with no item outstanding: %h", got);
        mismatches++;
        return;
      end
      want = expected_rgb.pop_front();
      colors_checked++;
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  hsr_in_t  item_i = '0;
  logic     valid_o;
  hsr_out_t result_o;

  rgb_scoreboard sb = new();

  hue_saturation_to_rgb uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watch both sides at every edge. Inputs change only through NBAs at the
  // edge, so what is seen here is what the converter saw.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_item(item_i);
    if (rst_ni && valid_o) sb.check_color(result_o);
  end

  // Mostly in-range pairs; about one in ten hues wraps past 360 and one in
  // ten saturations lands above 100.
  function automatic hsr_in_t random_color_request();
    hsr_in_t req;
    req.hue_degrees = (($urandom_range(0, 9) == 0) ? 9'($urandom_range(361, 511))
                                                    : 9'($urandom_range(0, 360)));
    req.saturation_percent = (($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                                           : 7'($urandom_range(0, 100)));
    return req;
  endfunction

  // Present one item and hold it until the converter takes it
  task automatic send_item(hsr_in_t req);
    start  <= 1'b1;
    item_i <= req;
    do @(posedge clk_i); while (busy);
  endtask

  // Sender gap: start low, junk on the item bus
  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) begin
      item_i <= hsr_in_t'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Hold off until every predicted color has been seen or the guard runs out
  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    while (sb.pending() != 0 && guard < DrainGuard) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic run_corners();
    // Primary and secondary hues and two between them at full color, the last
    // degree, 360 and wraps past it, then white, clamped and partial saturations.
    int unsigned hues[21] = '{0, 30, 60, 90, 120, 180, 240, 300, 359, 360, 361,
                              420, 511, 0, 120, 240, 45, 200, 511, 0, 256};
    int unsigned sats[21] = '{100, 100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
                              100, 100, 0, 0, 1, 50, 99, 127, 101, 127};
    hsr_in_t req;
    foreach (hues[i]) begin
      req.hue_degrees        = 9'(hues[i]);
      req.saturation_percent = 7'(sats[i]);
      send_item(req);
    end
  endtask

  // Each cycle the sender idles with the given odds, so that share of
  // cycles carries no item
  task automatic run_random(int unsigned count, int unsigned idle_pct);
    for (int unsigned n = 0; n < count; n++) begin
      while ($urandom_range(0, 99) < idle_pct) idle_cycles(1);
      send_item(random_color_request());
    end
  endtask

  // Stimulus
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_corners();
    drain_results();

    // Light gaps, then heavy gaps, then back to back
    run_random(RandomItems / 3, 10);
    drain_results();
    run_random(RandomItems / 3, 45);
    drain_results();
    run_random(RandomItems - 2 * (RandomItems / 3), 0);

    drain_results();
    repeat (PipeDepth + 4) @(posedge clk_i);

    if (sb.pending() != 0) begin
      $error("%0d color results never arrived", sb.pending());
      sb.mismatches += sb.pending();
    end

    $display("Ran %0d items (%0d colors checked): %0d hue wraps, %0d clamped",
             sb.items_seen, sb.colors_checked, sb.hue_wraps, sb.sat_clamps);
    $display("saturations, %0d whites, sender gaps at 10%%, 45%% and none.",
             sb.whites);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #500000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
